// ----- design/kdlp_pkg.sv -----
package kdlp_pkg;

  localparam int KEY_W = 5;
  localparam int CNT_W = 8;

  localparam logic [KEY_W-1:0] KEY_NONE = 5'd0;
  localparam logic [KEY_W-1:0] KEY_S12  = 5'd12;
  localparam logic [KEY_W-1:0] KEY_S13  = 5'd13;
  localparam logic [KEY_W-1:0] KEY_S16  = 5'd16;
  localparam logic [KEY_W-1:0] KEY_S17  = 5'd17;

  localparam logic [CNT_W-1:0] CNT_MAX            = 8'd255;
  localparam logic [CNT_W-1:0] LONG_TICKS_DEFAULT = 8'd50;

  // register indexes
  localparam logic REG_LONG_TICKS = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_CONFIRM = 3'd1,
    PH_PLAIN   = 3'd2,
    PH_COUNT13 = 3'd3,
    PH_SILENT  = 3'd4,
    PH_COUNT12 = 3'd5
  } phase_t;

endpackage

// ----- design/key_debounce_long_press_unit.sv -----
// Output: a result is registered and is on the output in the cycle after the tick that causes it is transferred.
// Throughput: one tick per cycle; in_ready = !out_valid || out_ready, so only a stalled
//   result held in the single output register holds off the next tick.
// Reset (rst, synchronous, active high): phase idle, held key and count cleared,
//   long_press_ticks back to 50, output register empty.
module key_debounce_long_press_unit
  import kdlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        key_s12,
  input  logic        key_s13,
  input  logic        key_s16,
  input  logic        key_s17,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  event_key,
  output logic        long_press,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  phase_t           phase, phase_next;
  logic [KEY_W-1:0] held_key, held_key_next;
  logic [CNT_W-1:0] hold_count, hold_count_next;
  logic [CNT_W-1:0] long_press_ticks;
  logic [KEY_W-1:0] scan_key;
  logic [CNT_W-1:0] count_inc;
  logic             emit;
  logic             emit_long;
  logic             in_xfer;

  assign pready   = 1'b1;
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks <= LONG_TICKS_DEFAULT;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LONG_TICKS) begin
      long_press_ticks <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LONG_TICKS) begin
      prdata = {{(32-CNT_W){1'b0}}, long_press_ticks};
    end
  end

  // scan priority 17 > 13 > 16 > 12
  always_comb begin
    if (key_s17) begin
      scan_key = KEY_S17;
    end else if (key_s13) begin
      scan_key = KEY_S13;
    end else if (key_s16) begin
      scan_key = KEY_S16;
    end else if (key_s12) begin
      scan_key = KEY_S12;
    end else begin
      scan_key = KEY_NONE;
    end
  end

  // saturating held-tick count
  assign count_inc = (hold_count < CNT_MAX) ? hold_count + 8'd1 : hold_count;

  // next state
  always_comb begin
    phase_next      = phase;
    held_key_next   = held_key;
    hold_count_next = hold_count;
    case (phase)
      PH_IDLE: begin
        if (scan_key != KEY_NONE) phase_next = PH_CONFIRM;
      end
      PH_CONFIRM: begin
        if (scan_key != KEY_NONE) begin
          held_key_next = scan_key;
          if (scan_key == KEY_S13) begin
            hold_count_next = '0;
            phase_next      = PH_COUNT13;
          end else if (scan_key == KEY_S12) begin
            hold_count_next = '0;
            phase_next      = PH_COUNT12;
          end else begin
            phase_next = PH_PLAIN;
          end
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_PLAIN: begin
        if (scan_key == KEY_NONE) phase_next = PH_IDLE;
      end
      PH_COUNT13, PH_COUNT12: begin
        if (scan_key != KEY_NONE) begin
          hold_count_next = count_inc;
          if (count_inc >= long_press_ticks) phase_next = PH_SILENT;
        end else begin
          phase_next = PH_IDLE;
        end
      end
      PH_SILENT: begin
        if (scan_key == KEY_NONE) phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  // result decode
  always_comb begin
    emit      = 1'b0;
    emit_long = 1'b0;
    case (phase)
      PH_PLAIN: begin
        emit = (scan_key == KEY_NONE);
      end
      PH_COUNT13, PH_COUNT12: begin
        if (scan_key != KEY_NONE) begin
          emit      = (count_inc >= long_press_ticks);
          emit_long = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_key   <= KEY_NONE;
      hold_count <= '0;
    end else if (in_xfer) begin
      phase      <= phase_next;
      held_key   <= held_key_next;
      hold_count <= hold_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      event_key  <= held_key;
      long_press <= emit_long;
    end
  end

  a_key_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (event_key == KEY_S12 || event_key == KEY_S13 ||
                   event_key == KEY_S16 || event_key == KEY_S17))
    else $error("reported key is not a valid key code");

  a_long_keys: assert property (@(posedge clk) disable iff (rst)
    (out_valid && long_press) |-> (event_key == KEY_S12 || event_key == KEY_S13))
    else $error("long press reported for key without hold counting");

  a_count_key: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_COUNT13) |-> (held_key == KEY_S13))
    else $error("counting phase does not match held key");

  a_in_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_emit_leaves: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && emit) |=> (phase == PH_IDLE || phase == PH_SILENT))
    else $error("phase after a result is neither idle nor silent");

endmodule
